>>> sv/sac_pkg.sv
// Shared types and constants for the set-associative LRU cache.
// Used by sac_ctrl, sac_dpath and set_associative_lru_cache; no dependencies.

package sac_pkg;

  // Fixed field widths of the request and response
  localparam int ADDR_W   = 32;
  localparam int DATA_W   = 64;
  localparam int STATUS_W = 3;
  localparam int WAYOUT_W = 2;
  localparam int STAMP_W  = 32;

  // Access kinds
  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  // Response status codes
  localparam logic [STATUS_W-1:0] ST_READ_HIT   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_READ_MISS  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_WRITE_HIT  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_WRITE_FILL = 3'd3;
  localparam logic [STATUS_W-1:0] ST_WRITE_EVICT = 3'd4;

  // Input request
  typedef struct packed {
    logic              mode;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
  } in_req_t;

  // Output response
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   read_data;
    logic [WAYOUT_W-1:0] way_used;
  } out_rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;        // capture request, read the set
    logic clear_step;  // clear one row of valid bits
    logic scan_start;  // begin LRU search
    logic scan_step;   // compare one more way's stamp
    logic commit;      // write back the line, load the response
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_done;  // last row is being cleared
    logic is_write;
    logic hit;
    logic has_empty;
    logic scan_done;
    logic out_free;    // response register can take a new response
  } sts_t;

endpackage

>>> sv/sac_ctrl.sv
// Control state machine for the set-associative LRU cache.
// Depends on sac_pkg for the command and status structs.

module sac_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  sac_pkg::sts_t sts,
  output sac_pkg::cmd_t cmd
);

  localparam logic [1:0] S_CLEAR  = 2'd0;
  localparam logic [1:0] S_IDLE   = 2'd1;
  localparam logic [1:0] S_LOOKUP = 2'd2;
  localparam logic [1:0] S_SCAN   = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       need_scan;

  assign in_stall  = (state_r != S_IDLE);
  assign need_scan = sts.is_write && !sts.hit && !sts.has_empty;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (need_scan) begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end else if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_SCAN: begin
        if (!sts.scan_done) begin
          cmd.scan_step = 1'b1;
        end else if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A load is always followed by the lookup cycle
  a_load_then_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_LOOKUP))
    else $error("lookup did not follow request load");

  // The LRU search never steps past the last way
  a_scan_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_step |-> !sts.scan_done)
    else $error("LRU scan stepped past last way");

  // No request taken before the valid bits are cleared
  a_no_load_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> (!cmd.load && !cmd.commit))
    else $error("access during valid clear");

endmodule

>>> sv/sac_dpath.sv
// Datapath of the set-associative LRU cache: line memories, tag compare,
// LRU search, use clock and response register. Depends on sac_pkg.

module sac_dpath #(
  parameter int SET_COUNT   = 64,
  parameter int WAYS        = 4,
  parameter int BLOCK_BYTES = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sac_pkg::in_req_t  in_req,
  input  sac_pkg::cmd_t     cmd,
  output sac_pkg::sts_t     sts,
  input  logic              out_stall,
  output logic              out_valid,
  output sac_pkg::out_rsp_t out_rsp
);

  localparam int OFF_W    = $clog2(BLOCK_BYTES);
  localparam int SET_BITS = $clog2(SET_COUNT);
  localparam int SET_W    = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int TAG_W    = sac_pkg::ADDR_W - OFF_W - SET_BITS;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CNT_W    = $clog2(WAYS + 1);
  localparam int BLK_W    = 8 * BLOCK_BYTES;
  localparam int STAMP_W  = sac_pkg::STAMP_W;

  // Request fields
  logic [SET_W-1:0] in_set;
  logic [TAG_W-1:0] in_tag;

  if (SET_BITS == 0) begin : g_one_set
    assign in_set = '0;
  end else begin : g_sets
    assign in_set = in_req.address[OFF_W +: SET_BITS];
  end
  assign in_tag = in_req.address[sac_pkg::ADDR_W-1 -: TAG_W];

  logic             mode_r;
  logic [SET_W-1:0] set_r;
  logic [TAG_W-1:0] tag_r;
  logic [BLK_W-1:0] wdata_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= in_req.mode;
      set_r   <= in_set;
      tag_r   <= in_tag;
      wdata_r <= in_req.write_data[BLK_W-1:0];
    end
  end

  // Registered read data of the addressed set
  logic [WAYS-1:0]    valid_rd_r;
  logic [TAG_W-1:0]   tag_rd_r   [WAYS];
  logic [BLK_W-1:0]   data_rd_r  [WAYS];
  logic [STAMP_W-1:0] stamp_rd_r [WAYS];

  // Lookup
  logic [WAYS-1:0]  hit_vec;
  logic [WAY_W-1:0] hit_way;
  logic [WAY_W-1:0] empty_way;
  logic             has_hit;
  logic             has_empty;

  always_comb begin
    hit_way   = '0;
    empty_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      hit_vec[w] = valid_rd_r[w] && (tag_rd_r[w] == tag_r);
      if (hit_vec[w]) begin
        hit_way = WAY_W'(w);
      end
      if (!valid_rd_r[w]) begin
        empty_way = WAY_W'(w);
      end
    end
    has_hit   = |hit_vec;
    has_empty = ~&valid_rd_r;
  end

  // LRU search, one way per cycle
  logic [CNT_W-1:0]   scan_cnt_r;
  logic [STAMP_W-1:0] best_stamp_r;
  logic [WAY_W-1:0]   best_way_r;
  logic [STAMP_W-1:0] scan_stamp;

  assign scan_stamp = stamp_rd_r[scan_cnt_r[WAY_W-1:0]];

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_cnt_r   <= CNT_W'(1);
      best_stamp_r <= stamp_rd_r[0];
      best_way_r   <= '0;
    end else if (cmd.scan_step) begin
      scan_cnt_r <= scan_cnt_r + CNT_W'(1);
      if (scan_stamp < best_stamp_r) begin
        best_stamp_r <= scan_stamp;
        best_way_r   <= scan_cnt_r[WAY_W-1:0];
      end
    end
  end

  // Way chosen for the commit and what gets written
  logic             is_write;
  logic             do_stamp;
  logic             do_fill;
  logic [WAY_W-1:0] sel_way;
  logic [WAYS-1:0]  sel_onehot;

  assign is_write = (mode_r == sac_pkg::MODE_WRITE);
  assign do_stamp = cmd.commit && (has_hit || is_write);
  assign do_fill  = cmd.commit && is_write && !has_hit;

  always_comb begin
    priority if (has_hit) begin
      sel_way = hit_way;
    end else if (has_empty) begin
      sel_way = empty_way;
    end else begin
      sel_way = best_way_r;
    end
    sel_onehot = WAYS'(1) << sel_way;
  end

  // Use clock
  logic [STAMP_W-1:0] use_clock_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_clock_r <= '0;
    end else if (do_stamp) begin
      use_clock_r <= use_clock_r + STAMP_W'(1);
    end
  end

  // Valid bits: one row per set, cleared by a sweep after reset
  logic [WAYS-1:0]  valid_mem [SET_COUNT];
  logic [SET_W-1:0] clr_cnt_r;
  logic             valid_we;
  logic [SET_W-1:0] valid_wa;
  logic [WAYS-1:0]  valid_wd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear_step) begin
      clr_cnt_r <= clr_cnt_r + SET_W'(1);
    end
  end

  assign valid_we = cmd.clear_step || do_fill;
  assign valid_wa = cmd.clear_step ? clr_cnt_r : set_r;
  assign valid_wd = cmd.clear_step ? '0 : (valid_rd_r | sel_onehot);

  always_ff @(posedge clk) begin
    if (valid_we) begin
      valid_mem[valid_wa] <= valid_wd;
    end
    if (cmd.load) begin
      valid_rd_r <= valid_mem[in_set];
    end
  end

  // Per-way tag, data and stamp memories
  for (genvar w = 0; w < WAYS; w++) begin : g_way
    logic [TAG_W-1:0]   tag_mem   [SET_COUNT];
    logic [BLK_W-1:0]   data_mem  [SET_COUNT];
    logic [STAMP_W-1:0] stamp_mem [SET_COUNT];

    always_ff @(posedge clk) begin
      if (do_fill && sel_onehot[w]) begin
        tag_mem[set_r] <= tag_r;
      end
      if (cmd.load) begin
        tag_rd_r[w] <= tag_mem[in_set];
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.commit && is_write && sel_onehot[w]) begin
        data_mem[set_r] <= wdata_r;
      end
      if (cmd.load) begin
        data_rd_r[w] <= data_mem[in_set];
      end
    end

    always_ff @(posedge clk) begin
      if (do_stamp && sel_onehot[w]) begin
        stamp_mem[set_r] <= use_clock_r;
      end
      if (cmd.load) begin
        stamp_rd_r[w] <= stamp_mem[in_set];
      end
    end
  end

  // Response register
  logic                       out_valid_r;
  sac_pkg::out_rsp_t          out_rsp_r;
  logic [sac_pkg::STATUS_W-1:0] rsp_status;

  always_comb begin
    priority if (!is_write) begin
      rsp_status = has_hit ? sac_pkg::ST_READ_HIT : sac_pkg::ST_READ_MISS;
    end else if (has_hit) begin
      rsp_status = sac_pkg::ST_WRITE_HIT;
    end else if (has_empty) begin
      rsp_status = sac_pkg::ST_WRITE_FILL;
    end else begin
      rsp_status = sac_pkg::ST_WRITE_EVICT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_rsp_r.status <= rsp_status;
      if (!is_write && has_hit) begin
        out_rsp_r.read_data <= sac_pkg::DATA_W'(data_rd_r[hit_way]);
      end else begin
        out_rsp_r.read_data <= '0;
      end
      if (!is_write && !has_hit) begin
        out_rsp_r.way_used <= '0;
      end else begin
        out_rsp_r.way_used <= sac_pkg::WAYOUT_W'(sel_way);
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // Status to the controller
  assign sts.clear_done = (clr_cnt_r == SET_W'(SET_COUNT - 1));
  assign sts.is_write   = is_write;
  assign sts.hit        = has_hit;
  assign sts.has_empty  = has_empty;
  assign sts.scan_done  = (scan_cnt_r == CNT_W'(WAYS));
  assign sts.out_free   = !out_valid_r || !out_stall;

  // A response is only loaded into a free register
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || !out_stall))
    else $error("response overwritten while stalled");

  // A tag lives in at most one way of a set
  a_hit_unique: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> $onehot0(hit_vec))
    else $error("tag present in more than one way");

  // Each stamping commit advances the use clock by one
  a_clock_step: assert property (@(posedge clk) disable iff (!rst_n)
    do_stamp |=> (use_clock_r == $past(use_clock_r) + STAMP_W'(1)))
    else $error("use clock did not advance");

endmodule

>>> sv/set_associative_lru_cache.sv
// Set-associative cache with LRU replacement and write allocate, one read or
// write of a whole block per request. After reset the block clears the valid
// bits, one set at a time, and takes no request in that time. A request then
// goes through a set read, then compare and write back; on a write miss into
// a full set an LRU search comes between the two, walking the stamps of the
// set one way per cycle. The response sits in an output register, so the
// next request is taken while it waits to be drained.
// Depends on sac_pkg, sac_ctrl and sac_dpath.

module set_associative_lru_cache #(
  parameter int SET_COUNT   = 64,
  parameter int WAYS        = 4,
  parameter int BLOCK_BYTES = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sac_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output sac_pkg::out_rsp_t out_data
);

  sac_pkg::cmd_t cmd;
  sac_pkg::sts_t sts;

  sac_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sac_dpath #(
    .SET_COUNT   (SET_COUNT),
    .WAYS        (WAYS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_rsp   (out_data)
  );

endmodule

>>> tb/tb.sv
// Self-checking testbench for set_associative_lru_cache: directed and random
// read/write requests checked against an in-bench LRU cache predictor.
// Depends on sac_pkg and the set_associative_lru_cache RTL.
`timescale 1ns / 1ps

module tb;

  localparam int SET_COUNT   = 64;
  localparam int WAYS        = 4;
  localparam int BLOCK_BYTES = 8;

  localparam int LINES  = SET_COUNT * WAYS;
  localparam int OFF_W  = $clog2(BLOCK_BYTES);
  localparam int SET_W  = $clog2(SET_COUNT);
  localparam int TAG_W  = sac_pkg::ADDR_W - OFF_W - SET_W;
  localparam logic [sac_pkg::DATA_W-1:0] BLOCK_MASK =
    (BLOCK_BYTES >= 8) ? {sac_pkg::DATA_W{1'b1}}
                       : ((64'd1 << (8 * BLOCK_BYTES)) - 64'd1);

  localparam int RANDOM_REQS    = 430;
  localparam int PRESSURE_HOLD  = 150;
  localparam int PRESSURE_REQS  = 16;
  localparam int DRAIN_CYCLES   = 2 * (WAYS + 2) + 8;
  localparam int WATCHDOG_LIMIT = 2000;

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  sac_pkg::in_req_t   in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  sac_pkg::out_rsp_t  out_data;

  set_associative_lru_cache #(
    .SET_COUNT   (SET_COUNT),
    .WAYS        (WAYS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Predicted cache contents
  bit                          mdl_valid [LINES];
  logic [TAG_W-1:0]            mdl_tag   [LINES];
  logic [sac_pkg::DATA_W-1:0]  mdl_data  [LINES];
  logic [sac_pkg::STAMP_W-1:0] mdl_stamp [LINES];
  logic [sac_pkg::STAMP_W-1:0] mdl_clock = '0;

  sac_pkg::out_rsp_t rsp_q[$];
  int unsigned fail_count = 0;
  int unsigned req_count  = 0;
  int unsigned rsp_count  = 0;
  int unsigned status_seen [8];

  // Receiver idling controls
  bit rx_idle_on = 1'b0;
  int hold_len   = 0;
  int stall_left = 0;
  int idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Gap length: mostly none or short, now and then long
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [sac_pkg::ADDR_W-1:0] block_addr(logic [TAG_W-1:0] tg,
                                                            int unsigned st,
                                                            int unsigned off);
    logic [sac_pkg::ADDR_W-1:0] a;
    a = sac_pkg::ADDR_W'(tg) << (SET_W + OFF_W);
    a = a | (sac_pkg::ADDR_W'(st % SET_COUNT) << OFF_W)
          | sac_pkg::ADDR_W'(off % BLOCK_BYTES);
    return a;
  endfunction

  function automatic void restamp(int unsigned line);
    mdl_stamp[line] = mdl_clock;
    mdl_clock = mdl_clock + 1'b1;
  endfunction

  // Predict one access and update the predicted cache state
  function automatic sac_pkg::out_rsp_t cache_access(sac_pkg::in_req_t r);
    int unsigned set_idx;
    int unsigned base;
    int unsigned way;
    int unsigned w;
    logic [TAG_W-1:0] tg;
    logic [sac_pkg::STAMP_W-1:0] oldest;
    bit hit;
    bit found_empty;
    sac_pkg::out_rsp_t rsp;
    set_idx = (r.address / BLOCK_BYTES) % SET_COUNT;
    tg = TAG_W'(r.address / (SET_COUNT * BLOCK_BYTES));
    base = set_idx * WAYS;
    hit = 1'b0;
    way = 0;
    rsp = '0;
    for (w = 0; w < WAYS; w++) begin
      if (!hit && mdl_valid[base + w] && mdl_tag[base + w] == tg) begin
        hit = 1'b1;
        way = w;
      end
    end
    if (r.mode == sac_pkg::MODE_READ) begin
      if (hit) begin
        rsp.read_data = mdl_data[base + way];
        restamp(base + way);
        rsp.status = sac_pkg::ST_READ_HIT;
      end else begin
        way = 0;
        rsp.status = sac_pkg::ST_READ_MISS;
      end
    end else if (hit) begin
      // write hit keeps tag and valid bit
      mdl_data[base + way] = r.write_data & BLOCK_MASK;
      restamp(base + way);
      rsp.status = sac_pkg::ST_WRITE_HIT;
    end else begin
      found_empty = 1'b0;
      for (w = 0; w < WAYS; w++) begin
        if (!found_empty && !mdl_valid[base + w]) begin
          found_empty = 1'b1;
          way = w;
        end
      end
      if (!found_empty) begin
        // plain unsigned compare, lowest way wins a tie
        oldest = mdl_stamp[base];
        way = 0;
        for (w = 1; w < WAYS; w++) begin
          if (mdl_stamp[base + w] < oldest) begin
            oldest = mdl_stamp[base + w];
            way = w;
          end
        end
      end
      mdl_valid[base + way] = 1'b1;
      mdl_tag[base + way]   = tg;
      mdl_data[base + way]  = r.write_data & BLOCK_MASK;
      restamp(base + way);
      rsp.status = found_empty ? sac_pkg::ST_WRITE_FILL : sac_pkg::ST_WRITE_EVICT;
    end
    rsp.way_used = sac_pkg::WAYOUT_W'(way);
    return rsp;
  endfunction

  function automatic sac_pkg::in_req_t make_req(logic md, logic [sac_pkg::ADDR_W-1:0] a,
                                                logic [sac_pkg::DATA_W-1:0] d);
    sac_pkg::in_req_t r;
    r.mode = md;
    r.address = a;
    r.write_data = d;
    return r;
  endfunction

  // Random access: mostly a few busy sets and a small tag pool, rest anywhere
  function automatic sac_pkg::in_req_t rand_access();
    logic [TAG_W-1:0] pool [6];
    logic [TAG_W-1:0] tg;
    int unsigned st;
    pool[0] = '0;
    pool[1] = '1;
    pool[2] = TAG_W'({(TAG_W / 2 + 1){2'b10}});
    pool[3] = TAG_W'({(TAG_W / 2 + 1){2'b01}});
    pool[4] = TAG_W'(1);
    pool[5] = TAG_W'(1) << (TAG_W - 1);
    st = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 3)
                                      : $urandom_range(0, SET_COUNT - 1);
    tg = ($urandom_range(0, 99) < 75) ? pool[3'($urandom_range(0, 5))] : TAG_W'($urandom);
    return make_req(1'($urandom), block_addr(tg, st, $urandom), {$urandom, $urandom});
  endfunction

  task automatic log_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // Offer one request after a gap, wait for it to be taken, predict its response
  task automatic send_req(input sac_pkg::in_req_t r, input int unsigned gap);
    sac_pkg::out_rsp_t exp_rsp;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    exp_rsp = cache_access(r);
    rsp_q.push_back(exp_rsp);
    status_seen[exp_rsp.status]++;
    req_count++;
  endtask

  // Right after reset every line must be invalid
  task automatic test_cold_reads();
    send_req(make_req(sac_pkg::MODE_READ, 32'h0000_0000, '1), 0);
    send_req(make_req(sac_pkg::MODE_READ, 32'hFFFF_FFFF, '0), 1);
    send_req(make_req(sac_pkg::MODE_READ, 32'h8000_0104, 64'h0123_4567_89AB_CDEF), 0);
  endtask

  // Extreme addresses and data, byte offset ignored inside a block
  task automatic test_block_extremes();
    send_req(make_req(sac_pkg::MODE_WRITE, 32'h0000_0000, '1), 0);
    send_req(make_req(sac_pkg::MODE_READ,  32'h0000_0000, '0), 0);
    send_req(make_req(sac_pkg::MODE_WRITE, 32'h0000_0007, '0), 2);
    send_req(make_req(sac_pkg::MODE_READ,  32'h0000_0003, '1), 0);
    send_req(make_req(sac_pkg::MODE_WRITE, 32'hFFFF_FFFF, 64'h5555_5555_5555_5555), 0);
    send_req(make_req(sac_pkg::MODE_READ,  32'hFFFF_FFF8, '0), 0);
    send_req(make_req(sac_pkg::MODE_WRITE, 32'hFFFF_FFFC, 64'hAAAA_AAAA_AAAA_AAAA), 0);
    send_req(make_req(sac_pkg::MODE_READ,  32'hFFFF_FFFF, '0), 3);
  endtask

  // Fill one set, refresh a line, then force two evictions
  task automatic test_lru_replace();
    int unsigned t;
    for (t = 1; t <= WAYS; t++)
      send_req(make_req(sac_pkg::MODE_WRITE, block_addr(TAG_W'(t), 5, t),
                        {$urandom, $urandom}), 0);
    send_req(make_req(sac_pkg::MODE_READ,  block_addr(TAG_W'(1), 5, 0), '0), 0);
    send_req(make_req(sac_pkg::MODE_WRITE, block_addr(TAG_W'(5), 5, 0),
                      {$urandom, $urandom}), 0);
    send_req(make_req(sac_pkg::MODE_READ,  block_addr(TAG_W'(2), 5, 0), '0), 0);
    send_req(make_req(sac_pkg::MODE_READ,  block_addr(TAG_W'(5), 5, 7), '0), 0);
    send_req(make_req(sac_pkg::MODE_WRITE, block_addr(TAG_W'(6), 5, 1),
                      {$urandom, $urandom}), 0);
  endtask

  // Receiver holds off while the sender keeps pushing requests
  task automatic test_backpressure();
    int unsigned i;
    hold_len <= PRESSURE_HOLD;
    for (i = 0; i < PRESSURE_REQS; i++) send_req(rand_access(), 0);
  endtask

  // Random traffic; every third stretch runs with no idling on either side
  task automatic test_random_traffic();
    int unsigned i;
    bit quiet;
    for (i = 0; i < RANDOM_REQS; i++) begin
      quiet = ((i / 60) % 3 == 1);
      rx_idle_on <= !quiet;
      send_req(rand_access(), quiet ? 0 : gap_len());
    end
  endtask

  // Receiver stall generator
  always @(posedge clk) begin
    if (hold_len > 0) begin
      out_stall <= 1'b1;
      hold_len  <= hold_len - 1;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (rx_idle_on && $urandom_range(0, 99) < 25) begin
      out_stall  <= 1'b1;
      stall_left <= gap_len();
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Response checker
  always @(posedge clk) begin
    sac_pkg::out_rsp_t exp_rsp;
    if (rst_n && out_valid && !out_stall) begin
      if (rsp_q.size() == 0) begin
        log_failure($sformatf("unexpected response: status %0d data %h way %0d",
                              out_data.status, out_data.read_data, out_data.way_used));
      end else begin
        exp_rsp = rsp_q.pop_front();
        if (out_data !== exp_rsp)
          log_failure($sformatf(
            {"response %0d mismatch: expected status %0d data %h way %0d, ",
             "got status %0d data %h way %0d"},
            rsp_count, exp_rsp.status, exp_rsp.read_data, exp_rsp.way_used,
            out_data.status, out_data.read_data, out_data.way_used));
      end
      rsp_count++;
    end
  end

  // Watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", idle_cycles);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    rx_idle_on <= 1'b1;
    @(posedge clk);

    test_cold_reads();
    test_block_extremes();
    test_lru_replace();
    test_backpressure();
    test_random_traffic();
    in_valid <= 1'b0;

    while (rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests: %0d read hits, %0d read misses, %0d write hits,",
             req_count, status_seen[sac_pkg::ST_READ_HIT],
             status_seen[sac_pkg::ST_READ_MISS], status_seen[sac_pkg::ST_WRITE_HIT]);
    $display("%0d fills of empty ways, %0d LRU replacements, %0d failures",
             status_seen[sac_pkg::ST_WRITE_FILL], status_seen[sac_pkg::ST_WRITE_EVICT],
             fail_count);
    if (fail_count == 0 && rsp_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
